>>> rtl/mt_pkg.sv
// Constants, state type and tempering function for the MT19937 generator core.
package mt_pkg;

	localparam int unsigned STATE_DEPTH  = 624;
	localparam int unsigned TWIST_OFFSET = 397;
	localparam int unsigned IDX_W        = $clog2(STATE_DEPTH + 1);

	localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(STATE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_DEPTH - 1);
	localparam logic [IDX_W-1:0] OFF_IDX   = IDX_W'(TWIST_OFFSET);
	localparam logic [IDX_W-1:0] WRAP_IDX  = IDX_W'(STATE_DEPTH - TWIST_OFFSET);

	localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [31:0] INIT_MULT    = 32'd1812433253;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
	localparam logic [31:0] SEED_RESET   = 32'd5489;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REFILL,
		ST_TW_PRIME,
		ST_TW_LOAD,
		ST_TW_RD,
		ST_TW_WR,
		ST_READ,
		ST_RDATA
	} mt_state_t;

	function automatic logic [31:0] temper(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

>>> rtl/mersenne_twister_generator_core.sv
// MT19937 generator core: state table memory, seeding, twisting and tempering.
//
// MT19937 uniform generator. Each item accepted on the slave stream returns one
// item on the master stream carrying the tempered 32-bit word y and the exact
// fixed-point fraction 2y+1 (uniform value = fraction / 2^33). The 624-word
// state sits in one synchronous dual-read memory; a draw reads one word, so an
// ordinary draw is accepted, read from memory and tempered into the result
// register. Every 624th draw first twists the whole table in place through the
// memory's two read ports and its write port. A draw with reseed set, and the
// first draw after reset, first refills the table from the seed register
// through the 1812433253 multiply recurrence (multiplier, then add and write)
// before that twist. The seed register is written over the cfg channel (always
// ready) and only takes effect at the next refill. A finished result waits in
// the output register while a new item is taken. No clearing pass follows
// reset: the table is always refilled before its first read.
module mersenne_twister_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: seed_value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] reseed, [7:1] zero
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [32:0] sample_fraction, [64:33] raw_word, [71:65] zero
);
	import mt_pkg::*;

	// state table: one write port, two registered read ports
	logic [31:0] state_mem_q [STATE_DEPTH];
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;

	mt_state_t        state_q, state_d;
	logic [IDX_W-1:0] cnt_q;      // refill / twist entry counter
	logic             phase_q;    // refill: 0 multiply, 1 add and write
	logic [IDX_W-1:0] idx_q;      // read index, DEPTH_IDX means twist due
	logic             seeded_q;
	logic [31:0]      seed_q;
	logic             out_valid_q;
	logic [31:0]      raw_q;

	logic [31:0] p_q;             // previous refill word
	logic [31:0] prod_q;          // registered multiplier output
	logic [31:0] cur_q;           // old word at the twist position

	// control from the sequencer
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [31:0]      mem_wdata;
	logic             rd_en_a, rd_en_b;
	logic [IDX_W-1:0] rd_addr_a, rd_addr_b;
	logic             out_load;

	// datapath
	logic [31:0]      mix;
	logic [31:0]      prod_d;
	logic [31:0]      refill_val;
	logic [31:0]      tw_y;
	logic [31:0]      tw_val;
	logic [IDX_W-1:0] next_addr;
	logic [IDX_W-1:0] far_addr;
	logic [31:0]      tempered;

	assign cfg_ready  = 1'b1;
	assign mix        = p_q ^ (p_q >> 30);
	assign prod_d     = 32'(INIT_MULT * mix);
	assign refill_val = prod_q + 32'(cnt_q);

	assign next_addr = (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
	assign far_addr  = (cnt_q < WRAP_IDX) ? cnt_q + OFF_IDX : cnt_q - WRAP_IDX;

	// twist: rd_a_q holds word k+1 (already new for the last entry), rd_b_q the far word
	assign tw_y   = {cur_q[31], rd_a_q[30:0]};
	assign tw_val = rd_b_q ^ (tw_y >> 1) ^ (tw_y[0] ? TWIST_MATRIX : 32'd0);

	assign tempered = temper(rd_a_q);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, raw_q, raw_q, 1'b1};

	// sequencer
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = tw_val;
		rd_en_a   = 1'b0;
		rd_addr_a = next_addr;
		rd_en_b   = 1'b0;
		rd_addr_b = far_addr;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tdata[0] || !seeded_q) begin
						state_d = ST_REFILL;
					end else if (idx_q >= DEPTH_IDX) begin
						state_d = ST_TW_PRIME;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_REFILL: begin
				if (cnt_q == '0) begin
					mem_we    = 1'b1;
					mem_wdata = seed_q;
				end else if (phase_q) begin
					mem_we    = 1'b1;
					mem_wdata = refill_val;
					if (cnt_q == LAST_IDX) begin
						state_d = ST_TW_PRIME;
					end
				end
			end
			ST_TW_PRIME: begin
				rd_en_a   = 1'b1;
				rd_addr_a = '0;
				state_d   = ST_TW_LOAD;
			end
			ST_TW_LOAD: begin
				state_d = ST_TW_RD;
			end
			ST_TW_RD: begin
				rd_en_a = 1'b1;
				rd_en_b = 1'b1;
				state_d = ST_TW_WR;
			end
			ST_TW_WR: begin
				mem_we  = 1'b1;
				state_d = (cnt_q == LAST_IDX) ? ST_READ : ST_TW_RD;
			end
			ST_READ: begin
				rd_en_a   = 1'b1;
				rd_addr_a = idx_q;
				state_d   = ST_RDATA;
			end
			ST_RDATA: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			phase_q     <= 1'b0;
			idx_q       <= DEPTH_IDX;
			seeded_q    <= 1'b0;
			seed_q      <= SEED_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				seed_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q   <= '0;
					phase_q <= 1'b0;
				end
				ST_REFILL: begin
					if (cnt_q == '0) begin
						cnt_q   <= cnt_q + 1'b1;
						phase_q <= 1'b0;
					end else if (!phase_q) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						if (cnt_q == LAST_IDX) begin
							cnt_q    <= '0;
							idx_q    <= DEPTH_IDX;
							seeded_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_TW_PRIME: begin
					cnt_q <= '0;
				end
				ST_TW_WR: begin
					if (cnt_q == LAST_IDX) begin
						cnt_q <= '0;
						idx_q <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RDATA: begin
					if (out_load) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_REFILL) begin
			if (cnt_q == '0) begin
				p_q <= seed_q;
			end else if (!phase_q) begin
				prod_q <= prod_d;
			end else begin
				p_q <= refill_val;
			end
		end
		if (state_q == ST_TW_LOAD || state_q == ST_TW_WR) begin
			cur_q <= rd_a_q;
		end
		if (out_load) begin
			raw_q <= tempered;
		end
	end

	// state table memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			state_mem_q[mem_waddr] <= mem_wdata;
		end
		if (rd_en_a) begin
			rd_a_q <= state_mem_q[rd_addr_a];
		end
		if (rd_en_b) begin
			rd_b_q <= state_mem_q[rd_addr_b];
		end
	end

endmodule

>>> tb/mersenne_twister_generator_core_test.sv
// Self-checking testbench for the MT19937 generator core: directed table, then random phases.
`timescale 1ns / 1ps

module mersenne_twister_generator_core_test;

	// generator constants, kept apart from the design's own package
	localparam int unsigned   MT_N       = 624;
	localparam int unsigned   MT_M       = 397;
	localparam logic [31:0]   MT_MATRIX  = 32'h9908_b0df;
	localparam logic [31:0]   MT_UPPER   = 32'h8000_0000;
	localparam logic [31:0]   MT_LOWER   = 32'h7fff_ffff;
	localparam logic [31:0]   MT_MULT    = 32'd1812433253;
	localparam logic [31:0]   MT_MASK_B  = 32'h9d2c_5680;
	localparam logic [31:0]   MT_MASK_C  = 32'hefc6_0000;
	localparam logic [31:0]   MT_SEED_RST = 32'd5489;

	localparam int RAND_ITEMS  = 1550;
	localparam int SETTLE_CYC  = 2600;   // refill + twist + draw, with margin
	localparam int MAX_PRINTS  = 40;

	// one directed row: optional seed write before the item, then the item itself
	typedef struct packed {
		bit        wr_seed;
		bit [31:0] seed;
		bit        reseed;
		bit        known;
		bit [31:0] word;
	} dir_row_t;

	// laid out as on m_tdata: raw word above the fraction
	typedef struct packed {
		logic [31:0] word;
		logic [32:0] fraction;
	} mt_result_t;

	localparam int N_DIR = 20;
	localparam dir_row_t DIRECTED [0:N_DIR-1] = '{
		// first draw after reset seeds itself from the reset seed
		'{1'b0, 32'd0,          1'b0, 1'b1, 32'd3499211612},
		'{1'b0, 32'd0,          1'b0, 1'b1, 32'd581869302},
		'{1'b0, 32'd0,          1'b0, 1'b1, 32'd3890346734},
		// seed write alone leaves the running stream untouched
		'{1'b1, 32'd1,          1'b0, 1'b1, 32'd3586334585},
		'{1'b0, 32'd0,          1'b0, 1'b1, 32'd545404204},
		'{1'b0, 32'd0,          1'b1, 1'b1, 32'd1791095845},
		'{1'b0, 32'd0,          1'b0, 1'b1, 32'd4282876139},
		// extreme seeds
		'{1'b1, 32'h0000_0000,  1'b1, 1'b0, 32'd0},
		'{1'b0, 32'd0,          1'b0, 1'b0, 32'd0},
		'{1'b1, 32'hffff_ffff,  1'b1, 1'b0, 32'd0},
		'{1'b0, 32'd0,          1'b0, 1'b0, 32'd0},
		'{1'b0, 32'd0,          1'b1, 1'b0, 32'd0},
		'{1'b1, 32'd5489,       1'b0, 1'b0, 32'd0},
		'{1'b0, 32'd0,          1'b1, 1'b1, 32'd3499211612},
		'{1'b0, 32'd0,          1'b0, 1'b1, 32'd581869302},
		// back-to-back reseeds restart the stream
		'{1'b0, 32'd0,          1'b1, 1'b1, 32'd3499211612},
		'{1'b1, 32'h8000_0000,  1'b1, 1'b0, 32'd0},
		'{1'b1, 32'h7fff_ffff,  1'b1, 1'b0, 32'd0},
		'{1'b0, 32'd0,          1'b0, 1'b0, 32'd0},
		'{1'b1, 32'd5489,       1'b1, 1'b1, 32'd3499211612}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [0] reseed, [7:1] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;    // [32:0] sample_fraction, [64:33] raw_word, [71:65] zero

	mersenne_twister_generator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// predictor state: table, read position, seeded flag, seed register
	logic [31:0] pr_words [MT_N];
	int unsigned pr_pos;
	bit          pr_seeded;
	logic [31:0] pr_seed;

	mt_result_t  result_q [$];   // expected results, oldest first

	bit tx_calm;   // sender sends without gaps
	bit rx_calm;   // receiver never stalls

	int n_errors;
	int n_items;
	int n_reseeds;
	int n_checked;
	int n_seed_writes;
	int n_twists;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// generous ceiling: far beyond even an all-reseed run of this length
	initial begin
		#200_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
	                               input logic [63:0] want);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("[%0t] %s: got %h, expected %h", $time, what, got, want);
	endtask

	// ---- predictor ----------------------------------------------------

	function automatic void pr_refill();
		logic [31:0] p;
		pr_words[0] = pr_seed;
		for (int unsigned i = 1; i < MT_N; i++) begin
			p = pr_words[i-1];
			pr_words[i] = MT_MULT * (p ^ (p >> 30)) + i;
		end
		pr_pos    = MT_N;
		pr_seeded = 1'b1;
	endfunction

	// in-place twist; entries below k already hold their new values
	function automatic void pr_twist();
		logic [31:0] mix;
		for (int unsigned k = 0; k < MT_N; k++) begin
			mix = (pr_words[k] & MT_UPPER) | (pr_words[(k + 1) % MT_N] & MT_LOWER);
			pr_words[k] = pr_words[(k + MT_M) % MT_N] ^ (mix >> 1) ^
			              (mix[0] ? MT_MATRIX : 32'd0);
		end
		pr_pos = 0;
		n_twists++;
	endfunction

	function automatic logic [31:0] pr_temper(input logic [31:0] w);
		logic [31:0] t;
		t = w ^ (w >> 11);
		t = t ^ ((t << 7) & MT_MASK_B);
		t = t ^ ((t << 15) & MT_MASK_C);
		return t ^ (t >> 18);
	endfunction

	function automatic logic [31:0] predict_draw(input bit reseed);
		logic [31:0] y;
		if (reseed || !pr_seeded)
			pr_refill();
		if (pr_pos >= MT_N)
			pr_twist();
		y = pr_temper(pr_words[pr_pos]);
		pr_pos++;
		return y;
	endfunction

	// ---- stimulus helpers (entered and left at a falling edge) -------

	// one request; expectation is the typed word where given, else predicted
	task automatic send_request(input bit reseed, input bit known,
	                            input logic [31:0] known_word);
		int          gap;
		logic [31:0] y;
		mt_result_t  want;
		gap = tx_calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, reseed};
		do @(posedge clk); while (!s_tready);
		y = predict_draw(reseed);
		if (known)
			y = known_word;
		want.word     = y;
		want.fraction = {y, 1'b1};
		result_q.push_back(want);
		n_items++;
		if (reseed)
			n_reseeds++;
		@(negedge clk);
	endtask

	// hold the sender off until every outstanding result is back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (result_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_seed(input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		pr_seed = value;
		n_seed_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ---- result side ---------------------------------------------------

	initial begin : result_sink
		int         stall;
		mt_result_t got;
		mt_result_t want;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = m_tdata[64:0];
			if (result_q.size() == 0) begin
				report_mismatch("result with nothing expected", 64'(got.word), 64'd0);
			end else begin
				want = result_q.pop_front();
				if (got.fraction !== want.fraction)
					report_mismatch("sample_fraction", 64'(got.fraction), 64'(want.fraction));
				if (got.word !== want.word)
					report_mismatch("raw_word", 64'(got.word), 64'(want.word));
			end
			n_checked++;
			@(negedge clk);
		end
	end

	// ---- main sequence -------------------------------------------------

	initial begin : stimulus
		int          i;
		int          rate;
		int          phase_len;
		int          sent_rand;
		bit          phase_first;
		bit          rs;
		logic [31:0] seed;

		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		tx_calm   = 1'b0;
		rx_calm   = 1'b0;
		pr_seed   = MT_SEED_RST;
		pr_seeded = 1'b0;
		pr_pos    = MT_N;
		foreach (pr_words[k])
			pr_words[k] = '0;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		for (i = 0; i < N_DIR; i++) begin
			if (DIRECTED[i].wr_seed) begin
				wait_idle();
				write_seed(DIRECTED[i].seed);
			end
			send_request(DIRECTED[i].reseed, DIRECTED[i].known, DIRECTED[i].word);
		end

		// random phases; the first runs long enough to cross a twist boundary
		phase_first = 1'b1;
		sent_rand   = 0;
		while (sent_rand < RAND_ITEMS) begin
			if (phase_first) begin
				rate      = 0;
				phase_len = 700;
			end else begin
				rate      = $urandom_range(0, 3);
				phase_len = (rate == 3) ? $urandom_range(10, 40) : $urandom_range(20, 400);
			end
			wait_idle();
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			if (!phase_first) begin
				case ($urandom_range(0, 5))
					0: begin
						seed = 32'h0000_0000;
					end
					1: begin
						seed = 32'hffff_ffff;
					end
					2: begin
						seed = MT_SEED_RST;
					end
					default: begin
						seed = $urandom();
					end
				endcase
				write_seed(seed);
			end
			for (i = 0; i < phase_len && sent_rand < RAND_ITEMS; i++) begin
				case (rate)
					0: begin
						rs = 1'b0;
					end
					1: begin
						rs = ($urandom_range(0, 99) == 0);
					end
					2: begin
						rs = ($urandom_range(0, 19) == 0);
					end
					default: begin
						rs = ($urandom_range(0, 3) == 0);
					end
				endcase
				if (i == 0 && !phase_first)
					rs = 1'($urandom_range(0, 1));
				send_request(rs, 1'b0, 32'd0);
				sent_rand++;
			end
			phase_first = 1'b0;
		end

		// drain, then watch for strays over a full refill-and-twist span
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (result_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);

		$display("run covered %0d requests (%0d reseeding) and %0d seed writes",
		         n_items, n_reseeds, n_seed_writes);
		$display("%0d results checked across %0d table twists, %0d mismatches",
		         n_checked, n_twists, n_errors);
		if (n_errors == 0 && result_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
